// ===== hdl/perlin_noise_3d_unit_assert.svh =====
// Assertion macros for the 3D gradient noise unit.
// Used by pn3d_core and perlin_noise_3d_unit; needs clk and rst in scope.
`ifndef PERLIN_NOISE_3D_UNIT_ASSERT_SVH
`define PERLIN_NOISE_3D_UNIT_ASSERT_SVH

`define PN3D_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define PN3D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pn3d_pkg.sv =====
// Package for the 3D gradient noise unit: request kinds, table and fraction
// sizes, gradient selection, output widths. No dependencies.
`default_nettype none
package pn3d_pkg;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  localparam int TABLE_SIZE = 256;
  localparam int FRAC_BITS  = 16;

  localparam int OUT_W    = 18;
  localparam int OUT_FRAC = 16;

  // gradient term select: sign and axis for one corner
  typedef struct packed {
    logic       u_is_y;
    logic [1:0] v_sel;   // 0 = y, 1 = x, 2 = z
    logic       u_neg;
    logic       v_neg;
  } grad_sel_t;

  localparam logic [1:0] VSEL_Y = 2'd0;
  localparam logic [1:0] VSEL_X = 2'd1;
  localparam logic [1:0] VSEL_Z = 2'd2;

  function automatic grad_sel_t grad_decode(input logic [3:0] h);
    grad_sel_t g;
    g.u_is_y = h[3];
    if (!h[3] && !h[2]) g.v_sel = VSEL_Y;
    else if (h == 4'd12 || h == 4'd14) g.v_sel = VSEL_X;
    else g.v_sel = VSEL_Z;
    g.u_neg = h[0];
    g.v_neg = h[1];
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/pn3d_mulq.sv =====
// Registered signed fixed-point multiply, product truncated toward zero.
// Uses no package.
`default_nettype none
module pn3d_mulq #(
  parameter int W = 24,
  parameter int F = 16
) (
  input  wire               clk,
  input  wire signed [W-1:0] a,
  input  wire signed [W-1:0] b,
  output logic signed [W-1:0] p
);
  logic signed [2*W-1:0] prod;
  logic signed [2*W-1:0] mag;
  logic signed [2*W-1:0] q;
  always_comb begin
    prod = a * b;
    mag  = prod[2*W-1] ? -prod : prod;
    q    = mag >>> F;
    if (prod[2*W-1]) q = -q;
  end
  always_ff @(posedge clk) begin
    p <= q[W-1:0];
  end
endmodule
`default_nettype wire

// ===== hdl/pn3d_core.sv =====
// Sequencer: permutation table memory (two read ports), hashing, fade,
// gradient and lerp arithmetic through one shared multiplier.
// Depends on pn3d_pkg, pn3d_mulq and the assertion header.
`default_nettype none
`include "perlin_noise_3d_unit_assert.svh"
module pn3d_core (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  input  wire        req_type,
  input  wire [7:0]  table_index,
  input  wire [7:0]  table_value,
  input  wire [31:0] coord_x,
  input  wire [31:0] coord_y,
  input  wire [31:0] coord_z,
  input  wire        out_hold,
  output logic       busy,
  output logic       done,
  output logic signed [pn3d_pkg::OUT_W-1:0] result
);
  localparam int TABLE_SIZE = pn3d_pkg::TABLE_SIZE;
  localparam int FRAC_BITS  = pn3d_pkg::FRAC_BITS;
  localparam int AW = $clog2(TABLE_SIZE);
  localparam int W  = FRAC_BITS + 8;   // range +-128 with sign headroom
  localparam logic signed [W-1:0] ONE = W'(1) << FRAC_BITS;

  // table stores 8-bit bytes; index mod TABLE_SIZE
  logic [7:0] mem [TABLE_SIZE];
  logic [AW-1:0] ra0, ra1;
  logic [7:0] rd0, rd1;
  logic we;
  logic [AW-1:0] wa;
  logic [7:0] wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

  typedef enum logic [4:0] {
    S_IDLE, S_H0, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6,
    S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_G, S_L0, S_L1, S_L2, S_DONE
  } state_t;
  state_t state;

  logic [AW-1:0] cx, cy, cz, a_h, b_h;
  logic [AW-1:0] hx [4];
  logic [3:0]    hh [8];
  logic signed [W-1:0] fade_t [3];
  logic signed [W-1:0] fade_i [3];
  logic signed [W-1:0] val [8];
  logic [1:0] ax;
  logic [2:0] li;
  logic [1:0] fstep;

  logic signed [W-1:0] ma, mb, mp;
  pn3d_mulq #(.W(W), .F(FRAC_BITS)) u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  function automatic logic [AW-1:0] add_m(input logic [7:0] t, input logic [AW-1:0] c);
    logic [AW:0] s;
    s = {{(AW+1-8 > 0 ? AW+1-8 : 0){1'b0}}, t} + {1'b0, c};
    return s[AW-1:0];
  endfunction

  function automatic logic signed [W-1:0] sel_coord(input logic [31:0] raw);
    return {{(W-FRAC_BITS){1'b0}}, raw[FRAC_BITS-1:0]};
  endfunction

  function automatic logic signed [W-1:0] grad_v(input logic [3:0] h,
      input logic signed [W-1:0] x, input logic signed [W-1:0] y,
      input logic signed [W-1:0] z);
    pn3d_pkg::grad_sel_t g;
    logic signed [W-1:0] u, v;
    g = pn3d_pkg::grad_decode(h);
    u = g.u_is_y ? y : x;
    unique case (g.v_sel)
      pn3d_pkg::VSEL_Y: v = y;
      pn3d_pkg::VSEL_X: v = x;
      default:          v = z;
    endcase
    return (g.u_neg ? -u : u) + (g.v_neg ? -v : v);
  endfunction

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_F0, S_F1, S_F2, S_F3, S_F4, S_F5: begin
        ma = fade_t[ax];
        mb = fade_i[ax];
      end
      S_L0, S_L1, S_L2: begin
        ma = fade_t[ax];
        mb = val[{li[1:0], 1'b1}] - val[{li[1:0], 1'b0}];
      end
      default: ;
    endcase
  end

  // fade_t holds the fraction t; fade_i scratch. fstep walks:
  // 0: t*t, 1: (t*t)*t, 2: t*(6t-15), 3: ttt*(i+10)
  logic signed [W-1:0] ttt [3];
  logic signed [W-1:0] frac [3];
  logic signed [W-1:0] lsum;
  logic signed [W+1:0] rsat;

  always_comb begin
    rsat = {{2{lsum[W-1]}}, lsum};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
      we    <= 1'b0;
    end else begin
      we   <= (state == S_IDLE) && start && (req_type == pn3d_pkg::REQ_LOAD);
      done <= (state == S_L2) && !out_hold;
      unique case (state)
        S_IDLE: if (start) begin
          if (req_type == pn3d_pkg::REQ_LOAD) begin
            wa <= AW'(table_index);
            wd <= table_value;
            busy <= 1'b1;
            state <= S_DONE;
          end else begin
            busy <= 1'b1;
            cx <= coord_x[FRAC_BITS+AW-1:FRAC_BITS];
            cy <= coord_y[FRAC_BITS+AW-1:FRAC_BITS];
            cz <= coord_z[FRAC_BITS+AW-1:FRAC_BITS];
            frac[0] <= sel_coord(coord_x);
            frac[1] <= sel_coord(coord_y);
            frac[2] <= sel_coord(coord_z);
            ra0 <= coord_x[FRAC_BITS+AW-1:FRAC_BITS];
            ra1 <= coord_x[FRAC_BITS+AW-1:FRAC_BITS] + AW'(1);
            state <= S_H0;
          end
        end
        S_H0: state <= S_H1;
        S_H1: begin
          a_h <= add_m(rd0, cy);
          b_h <= add_m(rd1, cy);
          ra0 <= add_m(rd0, cy);
          ra1 <= add_m(rd0, cy) + AW'(1);
          state <= S_H2;
        end
        S_H2: begin
          ra0 <= b_h;
          ra1 <= b_h + AW'(1);
          state <= S_H3;
        end
        S_H3: begin
          hx[0] <= add_m(rd0, cz);   // aa
          hx[1] <= add_m(rd1, cz);   // ab
          ra0 <= add_m(rd0, cz);
          ra1 <= add_m(rd0, cz) + AW'(1);
          state <= S_H4;
        end
        S_H4: begin
          hx[2] <= add_m(rd0, cz);   // ba
          hx[3] <= add_m(rd1, cz);   // bb
          ra0 <= add_m(rd0, cz);
          ra1 <= add_m(rd0, cz) + AW'(1);
          state <= S_H5;
        end
        S_H5: begin
          hh[0] <= rd0[3:0]; hh[4] <= rd1[3:0];  // aa, aa+1
          ra0 <= hx[1];
          ra1 <= hx[1] + AW'(1);
          state <= S_H6;
        end
        S_H6: begin
          hh[1] <= rd0[3:0]; hh[5] <= rd1[3:0];  // ba, ba+1
          ra0 <= hx[3];
          ra1 <= hx[3] + AW'(1);
          fade_t[0] <= frac[0]; fade_t[1] <= frac[1]; fade_t[2] <= frac[2];
          fade_i[0] <= frac[0]; fade_i[1] <= frac[1]; fade_i[2] <= frac[2];
          ax <= 2'd0; fstep <= 2'd0;
          state <= S_F0;
        end
        S_F0: begin
          if (ax == 2'd0 && fstep == 2'd0) begin
            hh[2] <= rd0[3:0]; hh[6] <= rd1[3:0];  // ab, ab+1
          end
          state <= S_F1;
        end
        S_F1: begin
          if (ax == 2'd0 && fstep == 2'd0) begin
            hh[3] <= rd0[3:0]; hh[7] <= rd1[3:0];  // bb, bb+1
          end
          // mp = product of previous step
          unique case (fstep)
            2'd0: begin ttt[ax] <= mp; fade_i[ax] <= frac[ax]; fade_t[ax] <= mp; end
            2'd1: begin
              ttt[ax] <= mp;
              fade_t[ax] <= frac[ax];
              fade_i[ax] <= W'(6 * frac[ax] - 15 * ONE);
            end
            2'd2: begin fade_t[ax] <= ttt[ax]; fade_i[ax] <= W'(mp + 10 * ONE); end
            default: fade_t[ax] <= mp;
          endcase
          if (fstep == 2'd3) begin
            fstep <= 2'd0;
            if (ax == 2'd2) state <= S_G;
            else begin
              ax <= ax + 2'd1;
              fade_i[ax + 2'd1] <= frac[ax + 2'd1];
              state <= S_F0;
            end
          end else begin
            fstep <= fstep + 2'd1;
            state <= S_F0;
          end
        end
        S_G: begin
          for (int k = 0; k < 8; k++) begin
            val[k] <= grad_v(hh[k],
                k[0] ? frac[0] - ONE : frac[0],
                k[1] ? frac[1] - ONE : frac[1],
                k[2] ? frac[2] - ONE : frac[2]);
          end
          ax <= 2'd0; li <= 3'd0;
          state <= S_L0;
        end
        S_L0: state <= S_L1;   // multiplier busy
        S_L1: begin
          val[li[1:0]] <= val[{li[1:0], 1'b0}] + mp;
          if (ax == 2'd0 && li == 3'd3) begin ax <= 2'd1; li <= 3'd0; end
          else if (ax == 2'd1 && li == 3'd1) begin ax <= 2'd2; li <= 3'd0; end
          else if (ax == 2'd2) begin
            lsum <= val[0] + mp;
            state <= S_L2;
          end else li <= li + 3'd1;
          if (ax != 2'd2) state <= S_L0;
        end
        S_L2: if (!out_hold) begin
          if (rsat > 131071) result <= 18'sd131071;
          else if (rsat < -131072) result <= -18'sd131072;
          else result <= rsat[pn3d_pkg::OUT_W-1:0];
          state <= S_DONE;
        end
        default: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PN3D_ASSERT_NEXT(a_start_busy, start && !busy, busy, "busy did not rise on a request")
  `PN3D_ASSERT_IMPL(a_done_busy, done, busy, "done outside a request")
  `PN3D_ASSERT_IMPL(a_idle_free, state == S_IDLE, !busy, "busy while idle")
endmodule
`default_nettype wire

// ===== hdl/perlin_noise_3d_unit.sv =====
// 3D gradient noise unit: one request at a time. A load writes a table byte
// and the next request is taken once the write is done. An evaluate shows
// its Q2.16 result and takes no new request until it has finished, as the
// single shared multiplier does three fades and seven lerps in turn; an
// unaccepted result holds the next evaluate in its last step.
// rst is synchronous; the table is not cleared. Needs pn3d_pkg, pn3d_core.
`default_nettype none
`include "perlin_noise_3d_unit_assert.svh"
module perlin_noise_3d_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire [111:0] s_tdata,  // table_index, table_value, coord_x, y, z
  input  wire         s_tuser,  // req_type
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata   // noise_value
);
  logic busy, done, start;
  logic signed [pn3d_pkg::OUT_W-1:0] res;

  assign s_tready = !busy;
  assign start = s_tvalid && s_tready;

  pn3d_core u_core (
    .clk(clk), .rst(rst), .start(start), .req_type(s_tuser),
    .table_index(s_tdata[7:0]), .table_value(s_tdata[15:8]),
    .coord_x(s_tdata[47:16]), .coord_y(s_tdata[79:48]), .coord_z(s_tdata[111:80]),
    .out_hold(m_tvalid && !m_tready),
    .busy(busy), .done(done), .result(res)
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (done) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end
  assign m_tdata = {6'd0, res};

  `PN3D_ASSERT_IMPL(a_busy_block, busy, !s_tready, "input ready while busy")
  `PN3D_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `PN3D_ASSERT_IMPL(a_done_free, done, !m_tvalid, "result overwrote a waiting one")
endmodule
`default_nettype wire

// ===== dv/perlin_noise_3d_unit_test.sv =====
// Self-checking bench for perlin_noise_3d_unit: loads the permutation table,
// evaluates noise at directed and random points, checks each result against
// a fixed-point predictor kept here or a known zero; needs pn3d_pkg, the RTL.
`default_nettype none
module perlin_noise_3d_unit_test;

  localparam int  NUM_RANDOM = 1530;
  localparam longint ONE = 64'sd1 << 16;
  localparam int  CYCLE_LIMIT = 1500000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [111:0] s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [23:0]  m_tdata;

  perlin_noise_3d_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  typedef struct {
    logic        kind;
    logic [7:0]  idx;
    logic [7:0]  val;
    logic [31:0] px, py, pz;
    logic        known;
    logic [17:0] noise;
  } request_t;

  logic [7:0]  perm_copy [256];
  logic [17:0] noise_queue [$];
  int          errors;
  int          cycles;
  bit          hold_off;
  request_t    directed [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic longint mul_q(longint a, longint b);
    longint p;
    p = a * b;
    if (p < 0) return -((-p) >>> 16);
    return p >>> 16;
  endfunction

  function automatic longint fade_q(longint t);
    longint i2;
    i2 = mul_q(t, 6 * t - 15 * ONE) + 10 * ONE;
    return mul_q(mul_q(mul_q(t, t), t), i2);
  endfunction

  function automatic longint blend(longint t, longint a, longint b);
    return a + mul_q(t, b - a);
  endfunction

  function automatic longint corner_dot(logic [7:0] hash, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [17:0] noise_at(logic [31:0] px, logic [31:0] py,
                                           logic [31:0] pz);
    logic [7:0] cx, cy, cz, a, aa, ab, b, ba, bb;
    longint x, y, z, x1, y1, z1, u, v, w, r;
    cx = px[23:16]; cy = py[23:16]; cz = pz[23:16];
    x = px[15:0]; y = py[15:0]; z = pz[15:0];
    u = fade_q(x); v = fade_q(y); w = fade_q(z);
    x1 = x - ONE; y1 = y - ONE; z1 = z - ONE;
    a  = perm_copy[cx] + cy;
    aa = perm_copy[a] + cz;
    ab = perm_copy[8'(a + 1)] + cz;
    b  = perm_copy[8'(cx + 1)] + cy;
    ba = perm_copy[b] + cz;
    bb = perm_copy[8'(b + 1)] + cz;
    r = blend(w,
          blend(v, blend(u, corner_dot(perm_copy[aa], x, y, z),
                            corner_dot(perm_copy[ba], x1, y, z)),
                   blend(u, corner_dot(perm_copy[ab], x, y1, z),
                            corner_dot(perm_copy[bb], x1, y1, z))),
          blend(v, blend(u, corner_dot(perm_copy[8'(aa + 1)], x, y, z1),
                            corner_dot(perm_copy[8'(ba + 1)], x1, y, z1)),
                   blend(u, corner_dot(perm_copy[8'(ab + 1)], x, y1, z1),
                            corner_dot(perm_copy[8'(bb + 1)], x1, y1, z1))));
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[17:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // eager: offer the request at once, with no idle cycles before it
  task automatic send_request(request_t rq, bit eager = 1'b0);
    int gap;
    gap = eager ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= rq.kind;
    s_tdata  <= {rq.pz, rq.py, rq.px, rq.val, rq.idx};
    do @(posedge clk); while (!s_tready);
    if (rq.kind == pn3d_pkg::REQ_LOAD) perm_copy[rq.idx] = rq.val;
    else noise_queue.push_back(rq.known ? rq.noise : noise_at(rq.px, rq.py, rq.pz));
  endtask

  function automatic request_t load_req(logic [7:0] idx, logic [7:0] val);
    request_t rq;
    rq = '{default: '0};
    rq.kind = pn3d_pkg::REQ_LOAD; rq.idx = idx; rq.val = val;
    return rq;
  endfunction

  function automatic request_t eval_req(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                        logic known, logic [17:0] noise);
    request_t rq;
    rq = '{default: '0};
    rq.kind = pn3d_pkg::REQ_EVAL; rq.px = px; rq.py = py; rq.pz = pz;
    rq.known = known; rq.noise = noise;
    rq.idx = 8'($urandom); rq.val = 8'($urandom);
    return rq;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return {{16{1'b0}}, 16'($urandom)};
      2: return {{16{1'b1}}, 16'($urandom)};
      3: return {16'($urandom), 16'h0000};
      default: return {16'($urandom), 16'hffff};
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (noise_queue.size() == 0) report_mismatch("result with nothing expected");
      else begin
        logic [17:0] want;
        want = noise_queue.pop_front();
        if (m_tdata[17:0] !== want)
          report_mismatch($sformatf("noise got %h want %h", m_tdata[17:0], want));
      end
    end
  end

  // receiver: random stall per result, one long hold-off
  initial begin : receiver
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  initial begin : sender
    int wait_cycles;
    errors = 0; cycles = 0; hold_off = 0;
    rst = 1'b1; s_tvalid = 1'b0; s_tuser = 1'b0; s_tdata = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full table load, index and value extremes included
    for (int i = 0; i < 256; i++) send_request(load_req(8'(i), 8'(i * 151 + 7)));
    send_request(load_req(8'hff, 8'hff));
    send_request(load_req(8'h00, 8'h00));
    // lattice points give exactly zero
    directed.push_back(eval_req(32'h0, 32'h0, 32'h0, 1'b1, 18'h0));
    directed.push_back(eval_req(32'h00050000, 32'hfffb0000, 32'h80000000, 1'b1, 18'h0));
    directed.push_back(eval_req(32'h7fff0000, 32'h7fff0000, 32'h7fff0000, 1'b1, 18'h0));
    directed.push_back(eval_req(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, 'x));
    directed.push_back(eval_req(32'h80000000, 32'h80000001, 32'hffffffff, 1'b0, 'x));
    directed.push_back(eval_req(32'hffffffff, 32'h0000ffff, 32'h00008000, 1'b0, 'x));
    directed.push_back(eval_req(32'h00008000, 32'h00008000, 32'h00008000, 1'b0, 'x));
    directed.push_back(eval_req(32'hffff8000, 32'hfffe4000, 32'h0001c000, 1'b0, 'x));
    directed.push_back(eval_req(32'h00ffffff, 32'hff000001, 32'h12345678, 1'b0, 'x));
    directed.push_back(load_req(8'h12, 8'h0e));
    directed.push_back(load_req(8'h13, 8'h0c));
    directed.push_back(eval_req(32'h00128000, 32'h00004000, 32'h0000c000, 1'b0, 'x));
    foreach (directed[i]) send_request(directed[i]);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 300) hold_off = 1'b1;
      if ($urandom_range(0, 9) == 0)
        send_request(load_req(8'($urandom), 8'($urandom)), n >= 300 && n < 340);
      else
        send_request(eval_req(rand_coord(), rand_coord(), rand_coord(), 1'b0, 'x),
                     n >= 300 && n < 340);
    end
    s_tvalid <= 1'b0;

    wait_cycles = 0;
    while (noise_queue.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    if (errors == 0 && noise_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
